### design/dlts_pkg.sv
// Package with types, codes and helpers shared by the delta-list task scheduler.
`default_nettype none
package dlts_pkg;

  localparam int DEFAULT_MAX_TASKS = 16;
  localparam int DW = 29;
  localparam logic [31:0] TICK_RECIP = 32'hCCCCCCCD;
  localparam int TICK_SHIFT = 35;

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_DISPATCH = 2'd2,
    CMD_DELETE   = 2'd3
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NONE_DUE  = 2'd3
  } status_e_t;

  typedef struct packed {
    cmd_e_t      command;
    logic [7:0]  task_id;
    logic [31:0] delay_ms;
    logic [31:0] period_ms;
  } req_t;

  typedef struct packed {
    logic        run_valid;
    logic [7:0]  run_task_id;
    status_e_t   status;
    logic [4:0]  task_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_DIV, S_ADD_WR, S_L_RD, S_L_CHK, S_L_W2, S_T_RD, S_T_CHK,
    S_D_RD, S_D_CHK, S_X_RD, S_X_CHK, S_X_RD2, S_X_SUM, S_X_UNL, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_DIV, OP_ADDWR, OP_STEPADD, OP_LW1, OP_LW2, OP_TICK,
    OP_DISP, OP_XFOUND, OP_XSTEP, OP_RDNX, OP_XSUM, OP_XUNL, OP_FIN
  } dp_op_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic walk_more;
    logic in_list;
    logic last_more;
    logic found;
    logic delta_zero;
    logic period_nz;
  } dp_stat_t;

  // Exact division of a 32-bit value by ten through its reciprocal.
  function automatic logic [DW-1:0] div_tick(input logic [31:0] x);
    logic [63:0] p;
    p = 64'(x) * 64'(TICK_RECIP);
    return p[63:TICK_SHIFT];
  endfunction

endpackage
`default_nettype wire

### design/dlts_ctrl.sv
// Controller state machine that sequences the scheduler commands.
`default_nettype none
module dlts_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire dlts_pkg::cmd_e_t  command,
  input  wire dlts_pkg::dp_stat_t stat,
  output dlts_pkg::dp_op_t       op,
  output logic                   busy
);
  import dlts_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (command)
            CMD_ADD:      state_next = stat.full ? S_FIN : S_ADD_DIV;
            CMD_TICK:     state_next = stat.empty ? S_FIN : S_T_RD;
            CMD_DISPATCH: state_next = stat.empty ? S_FIN : S_D_RD;
            CMD_DELETE:   state_next = stat.empty ? S_FIN : S_X_RD;
            default:      state_next = S_FIN;
          endcase
        end
      end
      S_ADD_DIV: state_next = S_ADD_WR;
      S_ADD_WR:  state_next = S_L_RD;
      S_L_RD:    state_next = S_L_CHK;
      S_L_CHK:   state_next = stat.walk_more ? S_L_RD : S_L_W2;
      S_L_W2:    state_next = S_FIN;
      S_T_RD:    state_next = S_T_CHK;
      S_T_CHK:   state_next = S_FIN;
      S_D_RD:    state_next = S_D_CHK;
      S_D_CHK:   state_next = (stat.delta_zero && stat.period_nz) ? S_L_RD : S_FIN;
      S_X_RD:    state_next = S_X_CHK;
      S_X_CHK: begin
        if (stat.found) begin
          state_next = stat.last_more ? S_X_RD2 : S_X_UNL;
        end else begin
          state_next = stat.last_more ? S_X_RD : S_FIN;
        end
      end
      S_X_RD2:   state_next = S_X_SUM;
      S_X_SUM:   state_next = S_X_UNL;
      S_X_UNL:   state_next = S_FIN;
      S_FIN:     state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    op = OP_NONE;
    unique case (state)
      S_IDLE:    op = start ? OP_LATCH : OP_NONE;
      S_ADD_DIV: op = OP_DIV;
      S_ADD_WR:  op = OP_ADDWR;
      S_L_CHK:   op = stat.walk_more ? OP_STEPADD : OP_LW1;
      S_L_W2:    op = OP_LW2;
      S_T_CHK:   op = OP_TICK;
      S_D_CHK:   op = stat.delta_zero ? OP_DISP : OP_NONE;
      S_X_CHK:   op = stat.found ? OP_XFOUND : OP_XSTEP;
      S_X_RD2:   op = OP_RDNX;
      S_X_SUM:   op = OP_XSUM;
      S_X_UNL:   op = OP_XUNL;
      S_FIN:     op = OP_FIN;
      default:   op = OP_NONE;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule
`default_nettype wire

### design/dlts_dp.sv
// Datapath with the slot memories, list pointers, free map and result registers.
`default_nettype none
module dlts_dp #(
  parameter int MAX_TASKS = dlts_pkg::DEFAULT_MAX_TASKS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dlts_pkg::dp_op_t   op,
  input  wire dlts_pkg::req_t     request,
  output dlts_pkg::dp_stat_t      stat,
  output dlts_pkg::rsp_t          result,
  output logic                    done
);
  import dlts_pkg::*;

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  logic [7:0]    task_mem   [MAX_TASKS];
  logic [DW-1:0] delta_mem  [MAX_TASKS];
  logic [DW-1:0] period_mem [MAX_TASKS];
  logic [IW-1:0] next_mem   [MAX_TASKS];

  logic [7:0]    rd_task;
  logic [DW-1:0] rd_delta, rd_period;
  logic [IW-1:0] rd_next, rd_addr;

  logic [IW-1:0] head, cur, prev, nx, s, first_free;
  logic [CW-1:0] n, count;
  logic          pv;
  logic [MAX_TASKS-1:0] free_map;
  logic [DW-1:0] d, per, cur_delta;
  logic [7:0]    id_r;
  logic [31:0]   delay_r, period_r;
  status_e_t     status_r;
  logic          run_valid_r;
  logic [7:0]    run_id_r;
  logic          done_r;

  logic          delta_we, next_we;
  logic [IW-1:0] delta_wa, next_wa;
  logic [DW-1:0] delta_wd;
  logic [IW-1:0] next_wd;
  logic [DW:0]   sum;

  assign rd_addr = (op == OP_RDNX) ? nx : cur;

  always_comb begin
    first_free = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (free_map[i]) first_free = IW'(i);
    end
  end

  assign stat.full       = (free_map == '0);
  assign stat.empty      = (count == '0);
  assign stat.in_list    = (n < count);
  assign stat.walk_more  = (n < count) && (d >= rd_delta);
  assign stat.last_more  = ({1'b0, n} + (CW+1)'(1)) < {1'b0, count};
  assign stat.found      = (rd_task == id_r);
  assign stat.delta_zero = (rd_delta == '0);
  assign stat.period_nz  = (rd_period != '0);

  assign sum = {1'b0, rd_delta} + {1'b0, cur_delta};

  always_comb begin
    delta_we = 1'b0;
    delta_wa = s;
    delta_wd = d;
    next_we  = 1'b0;
    next_wa  = s;
    next_wd  = '0;
    case (op)
      OP_LW1: begin
        delta_we = 1'b1;
        next_we  = 1'b1;
        next_wd  = stat.in_list ? cur : '0;
      end
      OP_LW2: begin
        delta_we = stat.in_list;
        delta_wa = cur;
        delta_wd = cur_delta - d;
        next_we  = pv;
        next_wa  = prev;
        next_wd  = s;
      end
      OP_TICK: begin
        delta_we = !stat.delta_zero;
        delta_wa = cur;
        delta_wd = rd_delta - DW'(1);
      end
      OP_XSUM: begin
        delta_we = 1'b1;
        delta_wa = nx;
        delta_wd = sum[DW] ? {DW{1'b1}} : sum[DW-1:0];
      end
      OP_XUNL: begin
        next_we = pv;
        next_wa = prev;
        next_wd = nx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (delta_we) delta_mem[delta_wa] <= delta_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (op == OP_ADDWR) begin
      task_mem[s]   <= id_r;
      period_mem[s] <= per;
    end
    rd_task   <= task_mem[rd_addr];
    rd_delta  <= delta_mem[rd_addr];
    rd_period <= period_mem[rd_addr];
    rd_next   <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      count    <= '0;
      free_map <= '1;
      done_r   <= 1'b0;
    end else begin
      done_r <= (op == OP_FIN);
      case (op)
        OP_LATCH: begin
          if (request.command == CMD_ADD && !stat.full) begin
            free_map[first_free] <= 1'b0;
          end
        end
        OP_LW2:  count <= count + CW'(1);
        OP_DISP: begin
          head  <= rd_next;
          count <= count - CW'(1);
          if (rd_period == '0) free_map[cur] <= 1'b1;
        end
        OP_XUNL: begin
          if (!pv) head <= nx;
          free_map[cur] <= 1'b1;
          count <= count - CW'(1);
        end
        default: ;
      endcase
      if (op == OP_LW2 && !pv) head <= s;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        id_r        <= request.task_id;
        delay_r     <= request.delay_ms;
        period_r    <= request.period_ms;
        cur         <= head;
        n           <= '0;
        pv          <= 1'b0;
        s           <= first_free;
        run_valid_r <= 1'b0;
        run_id_r    <= '0;
        case (request.command)
          CMD_ADD:      status_r <= stat.full ? ST_FULL : ST_OK;
          CMD_TICK:     status_r <= stat.empty ? ST_NONE_DUE : ST_OK;
          CMD_DISPATCH: status_r <= ST_NONE_DUE;
          default:      status_r <= ST_NOT_FOUND;
        endcase
      end
      OP_DIV: begin
        d   <= div_tick(delay_r);
        per <= div_tick(period_r);
      end
      OP_STEPADD: begin
        d    <= d - rd_delta;
        prev <= cur;
        pv   <= 1'b1;
        cur  <= rd_next;
        n    <= n + CW'(1);
      end
      OP_LW1: cur_delta <= rd_delta;
      OP_DISP: begin
        run_valid_r <= 1'b1;
        run_id_r    <= rd_task;
        status_r    <= ST_OK;
        cur         <= rd_next;
        n           <= '0;
        pv          <= 1'b0;
        s           <= cur;
        d           <= rd_period;
      end
      OP_XFOUND: begin
        nx        <= rd_next;
        cur_delta <= rd_delta;
      end
      OP_XSTEP: begin
        prev <= cur;
        pv   <= 1'b1;
        cur  <= rd_next;
        n    <= n + CW'(1);
      end
      OP_XUNL: status_r <= ST_OK;
      default: ;
    endcase
  end

  assign result.run_valid   = run_valid_r;
  assign result.run_task_id = run_id_r;
  assign result.status      = status_r;
  assign result.task_count  = 5'(count);
  assign done = done_r;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_TASKS))
    else $error("Pending count exceeds the table size.");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == $past(count) + CW'(1) ||
                                 count == $past(count) - CW'(1)))
    else $error("Pending count moved by more than one.");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done_r |=> !done_r)
    else $error("Result strobe lasted more than one cycle.");

  a_run_ok: assert property (@(posedge clk) disable iff (rst)
    (done_r && run_valid_r) |-> (status_r == ST_OK))
    else $error("Dispatched task reported with a failing status.");
`endif

endmodule
`default_nettype wire

### design/delta_list_task_scheduler.sv
// Top level of the delta-list task scheduler: controller plus datapath.
// Add divides the delay and period by ten, writes the free slot, walks the list and links the entry in.
// Tick decrements the head delta if it is not zero; a dispatch of a due periodic task re-adds it.
// Delete walks to the match and adds its delta into its successor, if any, before unlinking it.
// The walk reads one slot at a time; an empty list or a full table sends a command straight to the finish.
// Synchronous reset empties the list at once; the result strobe cannot be stalled.
`default_nettype none
module delta_list_task_scheduler #(
  parameter int MAX_TASKS = dlts_pkg::DEFAULT_MAX_TASKS
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire dlts_pkg::req_t request,
  output logic                busy,
  output logic                done,
  output dlts_pkg::rsp_t      result
);
  import dlts_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  dlts_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (request.command),
    .stat    (stat),
    .op      (op),
    .busy    (busy)
  );

  dlts_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .request (request),
    .stat    (stat),
    .result  (result),
    .done    (done)
  );

endmodule
`default_nettype wire
